@@ src/can_multiframe_reassembler_defines.svh @@
// assertion macros shared by the reassembler rtl
// no dependencies; included by files that carry assertions
`ifndef CAN_MULTIFRAME_REASSEMBLER_DEFINES_SVH
`define CAN_MULTIFRAME_REASSEMBLER_DEFINES_SVH

// checked on every rising aclk edge outside reset
`define CANMFR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every rising aclk edge, reset included
`define CANMFR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ src/canmfr_pkg.sv @@
// constants and codes of the can multi-frame reassembler
// no dependencies; used by can_multiframe_reassembler and the bench
`timescale 1ns / 1ps

package canmfr_pkg;

    localparam int unsigned MAX_MSG_BYTES = 256;
    localparam int unsigned NUM_CHAN      = 4;
    localparam int unsigned MAX_WORDS     = 32;
    localparam int unsigned MSG_LIMIT     =
        (MAX_MSG_BYTES < MAX_WORDS * 8) ? MAX_MSG_BYTES : MAX_WORDS * 8;

    localparam int unsigned CH_W   = $clog2(NUM_CHAN);
    localparam int unsigned BUF_AW = $clog2(MAX_MSG_BYTES);
    localparam int unsigned MEM_AW = CH_W + BUF_AW;

    localparam int unsigned S_TDATA_W = 72;
    localparam int unsigned M_TDATA_W = 104;

    // result status codes
    localparam logic [2:0] STAT_DATA     = 3'd0;
    localparam logic [2:0] STAT_SHORT    = 3'd1;
    localparam logic [2:0] STAT_ORPHAN   = 3'd2;
    localparam logic [2:0] STAT_OVERRUN  = 3'd3;
    localparam logic [2:0] STAT_TOO_LONG = 3'd4;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DECODE = 6'b000010,
        ST_WRITE  = 6'b000100,
        ST_FETCH  = 6'b001000,
        ST_PUT    = 6'b010000,
        ST_ERR    = 6'b100000
    } state_t;

endpackage

@@ src/canmfr_ram.sv @@
// simple dual-port ram: one write port, one read port with registered data
// no dependencies; holds the per-channel payload buffers
`timescale 1ns / 1ps

module canmfr_ram #(
    parameter int unsigned DATA_W = 8,
    parameter int unsigned ADDR_W = 10
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/can_multiframe_reassembler.sv @@
// top level of the can multi-frame reassembler
// depends on canmfr_pkg, canmfr_ram and can_multiframe_reassembler_defines.svh
//
//  port group  | dir | tdata fields (low bit first)                      | tuser  | tlast
//  s_t*        | in  | frame_len, frame_bytes                            | -      | -
//  m_t*        | out | channel, opcode, subnode, func_id, msg_len,       | status | last
//              |     | chunk_bytes, data_word                            |        |
//
// a frame is taken only in idle; after decode, payload goes into the buffer ram one byte
// per cycle, and each result word is built one byte per cycle from the ram read port
// (or from the frame bytes in a single-frame message), then goes to the output register.
// reset clears the channel table at once; buffer contents are undefined until written.
// a stalled m_tready holds the block in its put or error state; the next frame may be taken
// while the final item still waits in the output register.
`timescale 1ns / 1ps
`include "can_multiframe_reassembler_defines.svh"

module can_multiframe_reassembler (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [canmfr_pkg::S_TDATA_W-1:0] s_tdata,   // frame_len, frame_bytes, zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [canmfr_pkg::M_TDATA_W-1:0] m_tdata,   // channel, opcode, subnode, func_id,
                                                        // msg_len, chunk_bytes, data_word,
                                                        // zero pad
    output logic [2:0]   m_tuser,   // status
    output logic         m_tlast
);

    localparam int unsigned AW  = canmfr_pkg::BUF_AW;
    localparam int unsigned MAW = canmfr_pkg::MEM_AW;
    localparam int unsigned NCH = canmfr_pkg::NUM_CHAN;
    localparam logic [11:0] LIMIT = 12'(canmfr_pkg::MSG_LIMIT);

    canmfr_pkg::state_t state_reg, state_next;

    logic [63:0] frame_reg, frame_next;
    logic [3:0]  dlc_reg, dlc_next;
    logic [63:0] pay_reg, pay_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [AW-1:0] wr_idx_reg, wr_idx_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic [3:0]  pos_reg, pos_next;
    logic [11:0] rem_reg, rem_next;
    logic [63:0] word_reg, word_next;
    logic [1:0]  ch_reg, ch_next;
    logic [14:0] hdr_reg, hdr_next;
    logic [11:0] len_reg, len_next;
    logic        src_mem_reg, src_mem_next;
    logic        complete_reg, complete_next;
    logic [2:0]  err_reg, err_next;

    logic        chan_open_reg [NCH];
    logic        chan_open_next [NCH];
    logic [14:0] chan_header_reg [NCH];
    logic [14:0] chan_header_next [NCH];
    logic [11:0] chan_total_reg [NCH];
    logic [11:0] chan_total_next [NCH];
    logic [11:0] chan_done_reg [NCH];
    logic [11:0] chan_done_next [NCH];

    logic        m_valid_reg, m_valid_next;
    logic [2:0]  m_status_reg, m_status_next;
    logic [1:0]  m_ch_reg, m_ch_next;
    logic [14:0] m_hdr_reg, m_hdr_next;
    logic [11:0] m_len_reg, m_len_next;
    logic [3:0]  m_chunk_reg, m_chunk_next;
    logic [63:0] m_word_reg, m_word_next;
    logic        m_last_reg, m_last_next;

    logic           out_free;
    logic           out_load;
    logic           mem_we;
    logic [7:0]     mem_rdata;
    logic [3:0]     chunk_w;
    logic           last_w;
    logic [3:0]     dlc;
    logic [7:0]     b0, b1;
    logic [1:0]     dec_ch;
    logic [11:0]    st_total;
    logic [3:0]     st_n;
    logic [3:0]     ct_n;
    logic [11:0]    cur_done, cur_total, ct_sum;
    logic [7:0]     in_byte;
    logic           byte_ok;

    canmfr_ram #(
        .DATA_W (8),
        .ADDR_W (MAW)
    ) u_buf (
        .clk   (aclk),
        .we    (mem_we),
        .waddr ({ch_reg, wr_idx_reg}),
        .wdata (pay_reg[7:0]),
        .raddr ({ch_reg, rd_idx_reg}),
        .rdata (mem_rdata)
    );

    assign out_free = !m_valid_reg || m_tready;
    assign mem_we   = (state_reg == canmfr_pkg::ST_WRITE) && (cnt_reg != 4'd0);
    assign s_tready = (state_reg == canmfr_pkg::ST_IDLE);

    // size of the word being built from the bytes still owed
    assign chunk_w = (rem_reg >= 12'd8) ? 4'd8 : rem_reg[3:0];
    assign last_w  = (rem_reg <= 12'd8);

    assign dlc      = (dlc_reg > 4'd8) ? 4'd8 : dlc_reg;
    assign b0       = frame_reg[7:0];
    assign b1       = frame_reg[15:8];
    assign dec_ch   = b0[5:4];
    assign st_total = {b0[3:0], b1};
    assign st_n     = dlc - 4'd4;
    assign ct_n     = dlc - 4'd1;
    assign cur_done  = chan_done_reg[dec_ch];
    assign cur_total = chan_total_reg[dec_ch];
    assign ct_sum    = cur_done + {8'd0, ct_n};

    assign in_byte = src_mem_reg ? mem_rdata : pay_reg[7:0];
    assign byte_ok = ((pos_reg - 4'd1) < chunk_w);

    always_comb begin
        state_next    = state_reg;
        frame_next    = frame_reg;
        dlc_next      = dlc_reg;
        pay_next      = pay_reg;
        cnt_next      = cnt_reg;
        wr_idx_next   = wr_idx_reg;
        rd_idx_next   = rd_idx_reg;
        pos_next      = pos_reg;
        rem_next      = rem_reg;
        word_next     = word_reg;
        ch_next       = ch_reg;
        hdr_next      = hdr_reg;
        len_next      = len_reg;
        src_mem_next  = src_mem_reg;
        complete_next = complete_reg;
        err_next      = err_reg;
        for (int i = 0; i < NCH; i++) begin
            chan_open_next[i]   = chan_open_reg[i];
            chan_header_next[i] = chan_header_reg[i];
            chan_total_next[i]  = chan_total_reg[i];
            chan_done_next[i]   = chan_done_reg[i];
        end
        out_load      = 1'b0;
        m_status_next = m_status_reg;
        m_ch_next     = m_ch_reg;
        m_hdr_next    = m_hdr_reg;
        m_len_next    = m_len_reg;
        m_chunk_next  = m_chunk_reg;
        m_word_next   = m_word_reg;
        m_last_next   = m_last_reg;

        unique case (state_reg)
            canmfr_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    dlc_next   = s_tdata[3:0];
                    frame_next = s_tdata[67:4];
                    state_next = canmfr_pkg::ST_DECODE;
                end
            end

            canmfr_pkg::ST_DECODE: begin
                priority if (dlc < 4'd2) begin
                    err_next   = canmfr_pkg::STAT_SHORT;
                    ch_next    = 2'd0;
                    state_next = canmfr_pkg::ST_ERR;
                end else if (b0[7] && !b0[6]) begin
                    // start frame
                    ch_next = dec_ch;
                    if (dlc < 4'd4) begin
                        err_next   = canmfr_pkg::STAT_SHORT;
                        state_next = canmfr_pkg::ST_ERR;
                    end else begin
                        chan_open_next[dec_ch] = 1'b0;
                        priority if (st_total > LIMIT) begin
                            err_next   = canmfr_pkg::STAT_TOO_LONG;
                            state_next = canmfr_pkg::ST_ERR;
                        end else if ({8'd0, st_n} > st_total) begin
                            err_next   = canmfr_pkg::STAT_OVERRUN;
                            state_next = canmfr_pkg::ST_ERR;
                        end else begin
                            chan_header_next[dec_ch] = {frame_reg[22:16], frame_reg[31:24]};
                            chan_total_next[dec_ch]  = st_total;
                            chan_done_next[dec_ch]   = {8'd0, st_n};
                            chan_open_next[dec_ch]   = ({8'd0, st_n} != st_total);
                            complete_next = ({8'd0, st_n} == st_total);
                            hdr_next      = {frame_reg[22:16], frame_reg[31:24]};
                            len_next      = st_total;
                            pay_next      = frame_reg >> 32;
                            cnt_next      = st_n;
                            wr_idx_next   = '0;
                            state_next    = canmfr_pkg::ST_WRITE;
                        end
                    end
                end else if (b0[7]) begin
                    // continuation frame
                    ch_next = dec_ch;
                    priority if (!chan_open_reg[dec_ch]) begin
                        err_next   = canmfr_pkg::STAT_ORPHAN;
                        state_next = canmfr_pkg::ST_ERR;
                    end else if (ct_sum > cur_total || cur_total > LIMIT) begin
                        chan_open_next[dec_ch] = 1'b0;
                        err_next   = canmfr_pkg::STAT_OVERRUN;
                        state_next = canmfr_pkg::ST_ERR;
                    end else begin
                        chan_done_next[dec_ch] = ct_sum;
                        if (ct_sum == cur_total) begin
                            chan_open_next[dec_ch] = 1'b0;
                        end
                        complete_next = (ct_sum == cur_total);
                        hdr_next      = chan_header_reg[dec_ch];
                        len_next      = cur_total;
                        pay_next      = frame_reg >> 8;
                        cnt_next      = ct_n;
                        wr_idx_next   = cur_done[AW-1:0];
                        state_next    = canmfr_pkg::ST_WRITE;
                    end
                end else begin
                    // single-frame message, emitted straight from the frame bytes
                    ch_next      = 2'd0;
                    hdr_next     = {b0[6:0], b1};
                    len_next     = {8'd0, dlc - 4'd2};
                    rem_next     = {8'd0, dlc - 4'd2};
                    pay_next     = frame_reg >> 16;
                    src_mem_next = 1'b0;
                    pos_next     = 4'd0;
                    state_next   = canmfr_pkg::ST_FETCH;
                end
            end

            canmfr_pkg::ST_WRITE: begin
                if (cnt_reg != 4'd0) begin
                    pay_next    = pay_reg >> 8;
                    wr_idx_next = wr_idx_reg + AW'(1);
                    cnt_next    = cnt_reg - 4'd1;
                end else if (complete_reg) begin
                    rem_next     = len_reg;
                    rd_idx_next  = '0;
                    pos_next     = 4'd0;
                    src_mem_next = 1'b1;
                    state_next   = canmfr_pkg::ST_FETCH;
                end else begin
                    state_next = canmfr_pkg::ST_IDLE;
                end
            end

            canmfr_pkg::ST_FETCH: begin
                // read address runs one byte ahead of the shift
                if (pos_reg < 4'd8) begin
                    rd_idx_next = rd_idx_reg + AW'(1);
                end
                if (pos_reg != 4'd0) begin
                    word_next = {(byte_ok ? in_byte : 8'd0), word_reg[63:8]};
                    pay_next  = pay_reg >> 8;
                end
                pos_next = pos_reg + 4'd1;
                if (pos_reg == 4'd8) begin
                    state_next = canmfr_pkg::ST_PUT;
                end
            end

            canmfr_pkg::ST_PUT: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    m_status_next = canmfr_pkg::STAT_DATA;
                    m_ch_next     = ch_reg;
                    m_hdr_next    = hdr_reg;
                    m_len_next    = len_reg;
                    m_chunk_next  = chunk_w;
                    m_word_next   = word_reg;
                    m_last_next   = last_w;
                    if (last_w) begin
                        state_next = canmfr_pkg::ST_IDLE;
                    end else begin
                        rem_next   = rem_reg - 12'd8;
                        pos_next   = 4'd0;
                        state_next = canmfr_pkg::ST_FETCH;
                    end
                end
            end

            canmfr_pkg::ST_ERR: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    m_status_next = err_reg;
                    m_ch_next     = ch_reg;
                    m_hdr_next    = '0;
                    m_len_next    = '0;
                    m_chunk_next  = '0;
                    m_word_next   = '0;
                    m_last_next   = 1'b1;
                    state_next    = canmfr_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = canmfr_pkg::ST_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= canmfr_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NCH; i++) begin
                chan_open_reg[i]   <= 1'b0;
                chan_header_reg[i] <= '0;
                chan_total_reg[i]  <= '0;
                chan_done_reg[i]   <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            for (int i = 0; i < NCH; i++) begin
                chan_open_reg[i]   <= chan_open_next[i];
                chan_header_reg[i] <= chan_header_next[i];
                chan_total_reg[i]  <= chan_total_next[i];
                chan_done_reg[i]   <= chan_done_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        frame_reg    <= frame_next;
        dlc_reg      <= dlc_next;
        pay_reg      <= pay_next;
        cnt_reg      <= cnt_next;
        wr_idx_reg   <= wr_idx_next;
        rd_idx_reg   <= rd_idx_next;
        pos_reg      <= pos_next;
        rem_reg      <= rem_next;
        word_reg     <= word_next;
        ch_reg       <= ch_next;
        hdr_reg      <= hdr_next;
        len_reg      <= len_next;
        src_mem_reg  <= src_mem_next;
        complete_reg <= complete_next;
        err_reg      <= err_next;
        m_status_reg <= m_status_next;
        m_ch_reg     <= m_ch_next;
        m_hdr_reg    <= m_hdr_next;
        m_len_reg    <= m_len_next;
        m_chunk_reg  <= m_chunk_next;
        m_word_reg   <= m_word_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {7'd0, m_word_reg, m_chunk_reg, m_len_reg, m_hdr_reg[5:0],
                       m_hdr_reg[11:6], m_hdr_reg[14:12], m_ch_reg};

    `CANMFR_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_tvalid, "output valid after reset")

    `CANMFR_ASSERT(a_no_overwrite, out_load |-> (!m_valid_reg || m_tready),
        "result register overwritten while held")

    `CANMFR_ASSERT(a_error_single,
        (m_valid_reg && m_status_reg != canmfr_pkg::STAT_DATA) |->
            (m_last_reg && m_chunk_reg == 4'd0 && m_word_reg == 64'd0),
        "error item not a lone empty item")

    `CANMFR_ASSERT(a_chunk_range, m_valid_reg |-> (m_chunk_reg <= 4'd8),
        "word holds more than eight bytes")

endmodule

@@ dv/tb_top.sv @@
// self-checking bench for can_multiframe_reassembler: streams can frames in, checks result items
// depends on canmfr_pkg and the reassembler rtl; carries its own reassembly predictor
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  channel;
        logic [2:0]  opcode;
        logic [5:0]  subnode;
        logic [5:0]  func_id;
        logic [11:0] msg_len;
        logic [3:0]  chunk_bytes;
        logic [63:0] data_word;
        logic        last;
    } word_t;

    typedef struct {
        logic [3:0]  code;
        logic [63:0] bytes;
        bit          pause;
    } frame_t;

    logic         aclk;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [71:0]  s_tdata  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    frame_t frames_to_send[$];
    word_t  due_words[$];
    int     mismatches = 0;
    int     cyc = 0;
    word_t  got_word;
    word_t  want_word;

    // predictor state
    logic        ch_open  [canmfr_pkg::NUM_CHAN];
    logic [14:0] ch_hdr   [canmfr_pkg::NUM_CHAN];
    logic [11:0] ch_total [canmfr_pkg::NUM_CHAN];
    logic [11:0] ch_done  [canmfr_pkg::NUM_CHAN];
    logic [7:0]  ch_buf   [canmfr_pkg::NUM_CHAN][canmfr_pkg::MAX_MSG_BYTES];
    logic [7:0]  single_bytes [8];

    // stretch with no idling on either side
    wire quiet = (cyc >= 1000) && (cyc < 2500);

    can_multiframe_reassembler DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    task automatic push_error(input logic [2:0] status, input int ch);
        word_t r;
        r = '0;
        r.status  = status;
        r.channel = 2'(ch);
        r.last    = 1'b1;
        due_words.push_back(r);
    endtask

    task automatic push_message(input int ch, input logic [14:0] hdr, input int len,
                                input bit from_chan);
        word_t r;
        int    words;
        int    cnt;
        words = (len + 7) / 8;
        if (words == 0) words = 1;
        if (words > canmfr_pkg::MAX_WORDS) words = canmfr_pkg::MAX_WORDS;
        for (int w = 0; w < words; w++) begin
            cnt = len - 8 * w;
            if (cnt > 8) cnt = 8;
            if (cnt < 0) cnt = 0;
            r = '0;
            r.status      = canmfr_pkg::STAT_DATA;
            r.channel     = 2'(ch);
            r.opcode      = hdr[14:12];
            r.subnode     = hdr[11:6];
            r.func_id     = hdr[5:0];
            r.msg_len     = 12'(len);
            r.chunk_bytes = 4'(cnt);
            for (int i = 0; i < cnt; i++)
                r.data_word[8*i +: 8] = from_chan ? ch_buf[ch][8*w + i]
                                                  : single_bytes[8*w + i];
            r.last = (w == words - 1);
            due_words.push_back(r);
        end
    endtask

    task automatic reassemble_frame(input logic [3:0] code, input logic [63:0] fb);
        logic [7:0] b [8];
        int         dlc;
        int         n;
        int         ch;
        int         total;
        dlc = (code > 4'd8) ? 8 : int'(code);
        for (int i = 0; i < 8; i++) b[i] = fb[8*i +: 8];
        if (dlc < 2) begin
            push_error(canmfr_pkg::STAT_SHORT, 0);
        end else if (!b[0][7]) begin
            n = dlc - 2;
            for (int i = 0; i < n; i++) single_bytes[i] = b[2 + i];
            push_message(0, {b[0][6:0], b[1]}, n, 1'b0);
        end else begin
            ch = int'(b[0][5:4]);
            if (!b[0][6]) begin
                if (dlc < 4) begin
                    push_error(canmfr_pkg::STAT_SHORT, ch);
                end else begin
                    ch_open[ch] = 1'b0;
                    total = int'({b[0][3:0], b[1]});
                    n = dlc - 4;
                    if (total > int'(canmfr_pkg::MSG_LIMIT)) begin
                        push_error(canmfr_pkg::STAT_TOO_LONG, ch);
                    end else if (n > total) begin
                        push_error(canmfr_pkg::STAT_OVERRUN, ch);
                    end else begin
                        for (int i = 0; i < n; i++) ch_buf[ch][i] = b[4 + i];
                        ch_hdr[ch]   = {b[2][6:0], b[3]};
                        ch_total[ch] = 12'(total);
                        ch_done[ch]  = 12'(n);
                        if (n == total) push_message(ch, ch_hdr[ch], total, 1'b1);
                        else ch_open[ch] = 1'b1;
                    end
                end
            end else begin
                n = dlc - 1;
                if (!ch_open[ch]) begin
                    push_error(canmfr_pkg::STAT_ORPHAN, ch);
                end else if (int'(ch_done[ch]) + n > int'(ch_total[ch])) begin
                    ch_open[ch] = 1'b0;
                    push_error(canmfr_pkg::STAT_OVERRUN, ch);
                end else begin
                    for (int i = 0; i < n; i++) ch_buf[ch][int'(ch_done[ch]) + i] = b[1 + i];
                    ch_done[ch] = ch_done[ch] + 12'(n);
                    if (ch_done[ch] == ch_total[ch]) begin
                        ch_open[ch] = 1'b0;
                        push_message(ch, ch_hdr[ch], int'(ch_total[ch]), 1'b1);
                    end
                end
            end
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // eight data bytes may also be coded as 9..15
    function automatic logic [3:0] dlc_for(input int nbytes);
        if (nbytes == 8 && $urandom_range(3) == 0) return 4'($urandom_range(15, 9));
        return 4'(nbytes);
    endfunction

    task automatic queue_frame(input logic [3:0] code, input logic [63:0] fb);
        frame_t f;
        f.code  = code;
        f.bytes = fb;
        f.pause = 1'b0;
        frames_to_send.push_back(f);
    endtask

    task automatic queue_pause();
        frame_t f;
        f.code  = '0;
        f.bytes = '0;
        f.pause = 1'b1;
        frames_to_send.push_back(f);
    endtask

    task automatic queue_start(input int ch, input int total, input int n,
                               input logic [14:0] hdr);
        logic [63:0] fb;
        logic [11:0] tot;
        fb  = rand64();
        tot = 12'(total);
        fb[7:0]   = {2'b10, 2'(ch), tot[11:8]};
        fb[15:8]  = tot[7:0];
        fb[22:16] = hdr[14:8];
        fb[31:24] = hdr[7:0];
        queue_frame(dlc_for(n + 4), fb);
    endtask

    task automatic queue_cont(input int ch, input int n);
        logic [63:0] fb;
        fb = rand64();
        fb[7:4] = {2'b11, 2'(ch)};
        queue_frame(dlc_for(n + 1), fb);
    endtask

    task automatic queue_single(input int n);
        logic [63:0] fb;
        fb = rand64();
        fb[7] = 1'b0;
        queue_frame(dlc_for(n + 2), fb);
    endtask

    task automatic queue_directed();
        logic [63:0] fb;
        queue_frame(4'd0, rand64());
        queue_frame(4'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_frame(4'd2, {48'h0, 16'hFF7F});
        queue_frame(4'd8, 64'h0);
        fb = rand64();
        fb[7] = 1'b0;
        queue_frame(4'd15, fb);
        // start frame without room for its header
        fb = rand64();
        fb[7:0] = 8'hB0;
        queue_frame(4'd3, fb);
        queue_start(1, 0, 0, 15'h7FFF);
        queue_start(2, 4095, 4, 15'h0);
        queue_start(0, int'(canmfr_pkg::MSG_LIMIT) + 1, 0, 15'($urandom));
        queue_start(0, 2, 4, 15'($urandom));
        queue_cont(2, 7);
        // restart on an open channel drops the old message
        queue_start(1, 20, 4, 15'($urandom));
        queue_start(1, 3, 3, 15'($urandom));
        // overrun on continuation, then the channel is closed
        queue_start(0, 10, 2, 15'($urandom));
        queue_cont(0, 7);
        queue_cont(0, 5);
        queue_cont(0, 1);
        queue_start(3, 12, 4, 15'($urandom));
        queue_cont(3, 7);
        queue_cont(3, 1);
        queue_pause();
    endtask

    task automatic queue_random_traffic(input int count);
        int left [canmfr_pkg::NUM_CHAN];
        int ch;
        int total;
        int n;
        int pick;
        logic [63:0] fb;
        for (int c = 0; c < canmfr_pkg::NUM_CHAN; c++) left[c] = 0;
        // one message at the full buffer size
        queue_start(2, int'(canmfr_pkg::MSG_LIMIT), 4, 15'($urandom));
        left[2] = int'(canmfr_pkg::MSG_LIMIT) - 4;
        for (int k = 0; k < count; k++) begin
            ch   = $urandom_range(canmfr_pkg::NUM_CHAN - 1);
            pick = $urandom_range(99);
            if (pick < 75) begin
                if (left[ch] > 0) begin
                    n = $urandom_range(1, (left[ch] < 7) ? left[ch] : 7);
                    queue_cont(ch, n);
                    left[ch] -= n;
                end else begin
                    if ($urandom_range(19) == 0)
                        total = $urandom_range(1) ? int'(canmfr_pkg::MSG_LIMIT)
                                                  : $urandom_range(255, 100);
                    else
                        total = $urandom_range(40);
                    n = $urandom_range(4);
                    if (n > total) n = total;
                    queue_start(ch, total, n, 15'($urandom));
                    left[ch] = total - n;
                end
            end else if (pick < 80) begin
                queue_single($urandom_range(6));
            end else if (pick < 84) begin
                queue_frame(4'($urandom_range(1)), rand64());
            end else if (pick < 87) begin
                fb = rand64();
                fb[7:6] = 2'b10;
                queue_frame(4'($urandom_range(3, 2)), fb);
            end else if (pick < 90) begin
                // orphan on a closed channel, possible overrun on an open one
                n = $urandom_range(1, 7);
                queue_cont(ch, n);
                left[ch] = (n > left[ch]) ? 0 : left[ch] - n;
            end else if (pick < 93) begin
                queue_start(ch, $urandom_range(4095, int'(canmfr_pkg::MSG_LIMIT) + 1),
                            $urandom_range(4), 15'($urandom));
                left[ch] = 0;
            end else if (pick < 96) begin
                n = $urandom_range(1, 4);
                queue_start(ch, $urandom_range(n - 1), n, 15'($urandom));
                left[ch] = 0;
            end else begin
                queue_frame(4'($urandom), rand64());
            end
            if (k == count / 2) queue_pause();
        end
        // finish whatever is still open
        for (int c = 0; c < canmfr_pkg::NUM_CHAN; c++) begin
            while (left[c] > 0) begin
                n = (left[c] < 7) ? left[c] : 7;
                queue_cont(c, n);
                left[c] -= n;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input word_t want, input word_t got);
        if (mismatches < 10) begin
            $display("%s: exp st=%0d ch=%0d op=%0d sn=%0d fn=%0d len=%0d cnt=%0d d=%h l=%0d",
                     what, want.status, want.channel, want.opcode, want.subnode,
                     want.func_id, want.msg_len, want.chunk_bytes, want.data_word, want.last);
            $display("%s: got st=%0d ch=%0d op=%0d sn=%0d fn=%0d len=%0d cnt=%0d d=%h l=%0d",
                     what, got.status, got.channel, got.opcode, got.subnode,
                     got.func_id, got.msg_len, got.chunk_bytes, got.data_word, got.last);
        end
        mismatches++;
    endtask

    always @(posedge aclk) cyc <= cyc + 1;

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            for (int c = 0; c < canmfr_pkg::NUM_CHAN; c++) begin
                ch_open[c]  = 1'b0;
                ch_hdr[c]   = '0;
                ch_total[c] = '0;
                ch_done[c]  = '0;
            end
        end else begin
            if (s_tvalid && s_tready) reassemble_frame(s_tdata[3:0], s_tdata[67:4]);
            if (!s_tvalid || s_tready) begin
                if (frames_to_send.size() != 0 && frames_to_send[0].pause) begin
                    if (due_words.size() == 0) void'(frames_to_send.pop_front());
                    s_tvalid <= 1'b0;
                end else if (frames_to_send.size() != 0 &&
                             (quiet || $urandom_range(99) >= 9)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0, frames_to_send[0].bytes, frames_to_send[0].code};
                    void'(frames_to_send.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= quiet || ($urandom_range(99) >= 9);
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_word.status      = m_tuser;
            got_word.channel     = m_tdata[1:0];
            got_word.opcode      = m_tdata[4:2];
            got_word.subnode     = m_tdata[10:5];
            got_word.func_id     = m_tdata[16:11];
            got_word.msg_len     = m_tdata[28:17];
            got_word.chunk_bytes = m_tdata[32:29];
            got_word.data_word   = m_tdata[96:33];
            got_word.last        = m_tlast;
            if (due_words.size() == 0) begin
                report_mismatch("unexpected item", '0, got_word);
            end else begin
                want_word = due_words.pop_front();
                if (got_word !== want_word) report_mismatch("wrong item", want_word, got_word);
            end
        end
    end

    initial begin
        queue_directed();
        queue_random_traffic(60);
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        while (frames_to_send.size() != 0 || s_tvalid || due_words.size() != 0)
            @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (due_words.size() != 0) begin
            $display("%0d result items never arrived", due_words.size());
            mismatches += due_words.size();
        end
        if (mismatches == 0) begin
            $display("can_multiframe_reassembler: match");
        end else begin
            $display("can_multiframe_reassembler: mismatch");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout waiting for the reassembler");
        $display("can_multiframe_reassembler: mismatch");
        $finish;
    end

endmodule
